FILE: rtl/converter_state_space_step_assert.svh
// Assertion helpers used by the converter state-space step controller.
`ifndef CONVERTER_STATE_SPACE_STEP_ASSERT_SVH
`define CONVERTER_STATE_SPACE_STEP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CSSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSSS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/csss_pkg.sv
package csss_pkg;

  localparam int ModelOrder = 6;
  localparam int TermCount  = ModelOrder + 1;
  localparam int DataW      = 32;
  localparam int CoefW      = 16;
  localparam int ProdW      = DataW + CoefW;
  localparam int AccW       = ProdW + 2;
  localparam int FracShift  = 14;
  localparam int RowW       = $clog2(ModelOrder);
  localparam int ColW       = $clog2(TermCount);

  // Column index that selects the drive term (B coefficient times sample)
  localparam logic [ColW-1:0] ColDrive = ColW'(ModelOrder);
  localparam logic [RowW-1:0] RowLast  = RowW'(ModelOrder - 1);
  localparam logic signed [AccW-1:0] RoundBias = AccW'(1 << (FracShift - 1));

  // System matrix A, Q2.14
  localparam logic signed [CoefW-1:0] CoefA [ModelOrder][ModelOrder] = '{
    '{16'sd15814, -16'sd282,   16'sd93,    -16'sd95,   16'sd85,    -16'sd411},
    '{16'sd12668, 16'sd2051,   16'sd3793,  16'sd1147,  16'sd2100,  16'sd12704},
    '{16'sd13563, -16'sd12324, -16'sd1566, 16'sd5405,  -16'sd7954, 16'sd6414},
    '{16'sd16299, 16'sd4350,   -16'sd6305, 16'sd6901,  16'sd6434,  16'sd4750},
    '{16'sd12530, -16'sd6824,  -16'sd7954, -16'sd5515, -16'sd1615, 16'sd11929},
    '{16'sd18114, 16'sd12431,  16'sd1932,  16'sd1226,  -16'sd3591, 16'sd2443}
  };

  // Input vector B, Q2.14
  localparam logic signed [CoefW-1:0] CoefB [ModelOrder] = '{
    16'sd772, 16'sd618, 16'sd662, 16'sd795, 16'sd611, 16'sd883
  };

  // Controller to datapath commands
  typedef struct packed {
    logic            load_u;
    logic            mul_en;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            first;
    logic            last;
    logic            commit;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;
  } dp_sts_t;

endpackage

FILE: rtl/csss_ctrl.sv
module csss_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  csss_pkg::dp_sts_t     sts_i,
  output csss_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StRun    = 2'd1;
  localparam logic [1:0] StDrain  = 2'd2;
  localparam logic [1:0] StCommit = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [csss_pkg::RowW-1:0] row_q, row_d;
  logic [csss_pkg::ColW-1:0] col_q, col_d;
  logic                      out_valid_q, out_valid_d;
  logic                      in_acc;
  logic                      can_commit;

  assign in_acc     = in_valid_i && in_ready_o;
  assign can_commit = !out_valid_q || out_ready_i;

  // Sequence the 42 multiply-accumulates, then drain and commit
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.row   = row_q;
    cmd_o.col   = col_q;
    cmd_o.first = (col_q == '0);
    cmd_o.last  = (col_q == csss_pkg::ColDrive);
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_u = 1'b1;
          row_d        = '0;
          col_d        = '0;
          state_d      = StRun;
        end
      end
      StRun: begin
        cmd_o.mul_en = 1'b1;
        if (col_q == csss_pkg::ColDrive) begin
          col_d = '0;
          if (row_q == csss_pkg::RowLast) begin
            state_d = StDrain;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      StDrain: begin
        if (!sts_i.pipe_busy) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        if (can_commit) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  `include "converter_state_space_step_assert.svh"

  `CSSS_ASSERT_IMP(a_commit_drained, cmd_o.commit, !sts_i.pipe_busy, "commit while busy")
  `CSSS_ASSERT_IMP(a_commit_no_overwrite, cmd_o.commit, can_commit, "result overwritten")
  `CSSS_ASSERT_NXT(a_accept_starts, in_acc, state_q == StRun && row_q == '0 && col_q == '0, "bad start")

endmodule

FILE: rtl/csss_dp.sv
module csss_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csss_pkg::ctrl_cmd_t                 cmd_i,
  output csss_pkg::dp_sts_t                   sts_o,
  input  logic signed [csss_pkg::DataW-1:0]   drive_sample_i,
  output logic signed [csss_pkg::DataW-1:0]   output_voltage_o
);

  localparam int DataW = csss_pkg::DataW;
  localparam int AccW  = csss_pkg::AccW;

  logic signed [DataW-1:0]          u_q;
  logic signed [DataW-1:0]          state_q [csss_pkg::ModelOrder];
  logic signed [DataW-1:0]          next_q  [csss_pkg::ModelOrder];
  logic signed [DataW-1:0]          out_q;
  logic signed [DataW-1:0]          op_data;
  logic signed [csss_pkg::CoefW-1:0] op_coef;
  logic signed [csss_pkg::ProdW-1:0] prod_d, prod_q;
  logic                             prod_vld_q, prod_first_q, prod_last_q;
  logic [csss_pkg::RowW-1:0]        prod_row_q, acc_row_q;
  logic signed [AccW-1:0]           acc_d, acc_q;
  logic                             acc_done_q;
  logic signed [AccW-1:0]           rnd_sum, rnd_shift;
  logic signed [DataW-1:0]          rnd_sat;

  // Select the operand pair for this term
  always_comb begin
    if (cmd_i.col == csss_pkg::ColDrive) begin
      op_data = u_q;
      op_coef = csss_pkg::CoefB[cmd_i.row];
    end else begin
      op_data = state_q[cmd_i.col[csss_pkg::RowW-1:0]];
      op_coef = csss_pkg::CoefA[cmd_i.row][cmd_i.col[csss_pkg::RowW-1:0]];
    end
  end

  assign prod_d = op_data * op_coef;

  // Accumulate the row, restarting on its first term
  assign acc_d = prod_first_q ? AccW'(prod_q) : acc_q + AccW'(prod_q);

  // Round half up to Q16.16 and clamp to the 32-bit range
  assign rnd_sum   = acc_q + csss_pkg::RoundBias;
  assign rnd_shift = rnd_sum >>> csss_pkg::FracShift;
  always_comb begin
    if (rnd_shift[AccW-1:DataW-1] == '0 || rnd_shift[AccW-1:DataW-1] == '1) begin
      rnd_sat = rnd_shift[DataW-1:0];
    end else if (rnd_shift[AccW-1]) begin
      rnd_sat = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      rnd_sat = {1'b0, {(DataW-1){1'b1}}};
    end
  end

  assign sts_o.pipe_busy = prod_vld_q || acc_done_q;
  assign output_voltage_o = out_q;

  // Pipeline control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mul_en;
      acc_done_q <= prod_vld_q && prod_last_q;
    end
  end

  // Plant state starts at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < csss_pkg::ModelOrder; i++) begin
        state_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < csss_pkg::ModelOrder; i++) begin
        state_q[i] <= next_q[i];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_u) begin
      u_q <= drive_sample_i;
    end
    if (cmd_i.mul_en) begin
      prod_q       <= prod_d;
      prod_first_q <= cmd_i.first;
      prod_last_q  <= cmd_i.last;
      prod_row_q   <= cmd_i.row;
    end
    if (prod_vld_q) begin
      acc_q     <= acc_d;
      acc_row_q <= prod_row_q;
    end
    if (acc_done_q) begin
      next_q[acc_row_q] <= rnd_sat;
    end
    if (cmd_i.commit) begin
      out_q <= next_q[csss_pkg::ModelOrder-1];
    end
  end

endmodule

FILE: rtl/converter_state_space_step.sv
// Sixth-order discrete converter model, one step per drive sample.
// Input channel: in_valid_i / in_ready_o carry drive_sample_i (signed Q16.16).
// Output channel: out_valid_o / out_ready_i carry output_voltage_o, the new
// sixth state (signed Q16.16, rounded half up, saturated).
// Each request runs 42 multiply-accumulates (six rows of seven terms) on one
// shared 32x16 multiplier, one term per cycle, then drains the product,
// accumulate and row-write registers and commits the new state. One item is
// in work at a time, so a new request is taken only after that commit.
// in_ready_o is high only while the unit is idle. A finished result waits in
// the output register; a new request may be taken meanwhile, but its commit
// holds until the earlier result has been taken.
// Reset clears the six plant states to zero and drops any pending result.
module converter_state_space_step (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [csss_pkg::DataW-1:0]   drive_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [csss_pkg::DataW-1:0]   output_voltage_o
);

  csss_pkg::ctrl_cmd_t cmd;
  csss_pkg::dp_sts_t   sts;

  // Sequencer
  csss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Multiply-accumulate datapath and state
  csss_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .drive_sample_i   (drive_sample_i),
    .output_voltage_o (output_voltage_o)
  );

endmodule

FILE: dv/converter_state_space_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the converter step, predicts each output voltage
// from the drive requests and compares the results in order.
module converter_state_space_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [csss_pkg::DataW-1:0] drive_sample_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [csss_pkg::DataW-1:0] output_voltage_i,
  output int                                mismatch_count_o,
  output int                                outstanding_o
);

  localparam int     Order   = 6;
  localparam longint VoltMax = 64'sd2147483647;
  localparam longint VoltMin = -64'sd2147483648;

  // Plant matrix and drive gains, Q2.14
  localparam int GainA [Order][Order] = '{
    '{15814,   -282,     93,    -95,     85,   -411},
    '{12668,   2051,   3793,   1147,   2100,  12704},
    '{13563, -12324,  -1566,   5405,  -7954,   6414},
    '{16299,   4350,  -6305,   6901,   6434,   4750},
    '{12530,  -6824,  -7954,  -5515,  -1615,  11929},
    '{18114,  12431,   1932,   1226,  -3591,   2443}
  };
  localparam int GainB [Order] = '{772, 618, 662, 795, 611, 883};

  logic signed [31:0] plant_x [Order];
  logic signed [31:0] expected_voltage_q [$];
  int                 mismatches;

  // Advance the plant by one drive sample and return the new output voltage
  function automatic logic signed [31:0] step_plant(input logic signed [31:0] drive);
    logic signed [31:0] next_x [Order];
    longint             acc;
    longint             q;
    for (int r = 0; r < Order; r++) begin
      acc = longint'(GainB[r]) * longint'(drive);
      for (int c = 0; c < Order; c++) begin
        acc += longint'(GainA[r][c]) * longint'(plant_x[c]);
      end
      // round half up to Q16.16, then clamp to the 32-bit range
      q = (acc + 64'sd8192) >>> 14;
      if (q > VoltMax) begin
        next_x[r] = 32'sh7fffffff;
      end else if (q < VoltMin) begin
        next_x[r] = 32'sh80000000;
      end else begin
        next_x[r] = q[31:0];
      end
    end
    for (int r = 0; r < Order; r++) begin
      plant_x[r] = next_x[r];
    end
    return plant_x[Order-1];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] want;
    if (!rst_ni) begin
      for (int i = 0; i < Order; i++) begin
        plant_x[i] = '0;
      end
      expected_voltage_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      // compare a result taken at this edge with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (expected_voltage_q.size() == 0) begin
          report_mismatch($sformatf("output_voltage %0d with no request outstanding",
                                    output_voltage_i));
        end else begin
          want = expected_voltage_q.pop_front();
          if (output_voltage_i !== want) begin
            report_mismatch($sformatf("output_voltage got %0d expected %0d",
                                      output_voltage_i, want));
          end
        end
      end
      // predict the result of a request taken at this edge
      if (in_valid_i && in_ready_i) begin
        expected_voltage_q.push_back(step_plant(drive_sample_i));
      end
      mismatch_count_o <= mismatches;
      outstanding_o <= expected_voltage_q.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int CycleLimit    = 500000;
  localparam int RandomItems   = 500;
  localparam int DrainCycles   = 60;
  localparam int HoldOffCycles = 400;
  localparam int HoldOffItems  = 8;
  localparam int IdlePercent   = 22;
  localparam int CalmFirst     = 200;
  localparam int CalmLast      = 280;

  // Corner drive values: zero, unit steps, bit patterns, and runs of both rails
  localparam logic signed [31:0] CornerDrive [20] = '{
    32'sh00000000, 32'sh00000001, 32'shffffffff, 32'sh00010000, 32'shffff0000,
    32'sh7fffffff, 32'sh80000000, 32'sh55555555, 32'shaaaaaaaa, 32'sh7fffffff,
    32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
    32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh00000000
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] drive_sample_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] output_voltage_o;

  int mismatch_count;
  int outstanding;
  int cycle_cnt = 0;
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;

  converter_state_space_step u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .drive_sample_i   (drive_sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .output_voltage_o (output_voltage_o)
  );

  converter_state_space_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .drive_sample_i   (drive_sample_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .output_voltage_i (output_voltage_o),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: stall at random, and once hold off for a long stretch
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles - 1) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // Offer one drive request and hold it until it is taken
  task automatic send_drive(input logic signed [31:0] v);
    in_valid_i <= 1'b1;
    drive_sample_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid for a random gap now and then
  task automatic idle_gap();
    if (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 50)) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every predicted voltage has been taken
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    logic signed [31:0] sample;
    logic signed [31:0] prev;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    foreach (CornerDrive[i]) begin
      idle_gap();
      send_drive(CornerDrive[i]);
    end

    // fill the block while the receiver holds off, then drain fully
    hold_off_req <= 1'b1;
    for (int i = 0; i < HoldOffItems; i++) begin
      send_drive($urandom());
    end
    wait_drained();

    // random drive samples, with a stretch where neither side idles
    prev = '0;
    for (int n = 0; n < RandomItems; n++) begin
      calm <= (n >= CalmFirst) && (n < CalmLast);
      case ($urandom_range(0, 3))
        0: sample = $urandom();
        1: sample = int'($urandom_range(0, 131072)) - 65536;
        2: begin
          case ($urandom_range(0, 3))
            0: sample = 32'sh7fffffff;
            1: sample = 32'sh80000000;
            2: sample = 32'sh00000000;
            default: sample = 32'shffffffff;
          endcase
        end
        default: sample = prev;
      endcase
      prev = sample;
      idle_gap();
      send_drive(sample);
    end

    calm <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/csss_pkg.sv
rtl/csss_ctrl.sv
rtl/csss_dp.sv
rtl/converter_state_space_step.sv
dv/converter_state_space_checker.sv
dv/tb_top.sv
